/* rtl/linear_ramp_generator_top_assert.svh */
// Assertion macros for the linear ramp generator.
// Every property is sampled on the rising clock edge and is off while reset is held.
`ifndef LINEAR_RAMP_GENERATOR_TOP_ASSERT_SVH
`define LINEAR_RAMP_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("linear ramp generator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("linear ramp generator: next-cycle check failed");

`endif

/* rtl/lrg_pkg.sv */
`default_nettype none

package lrg_pkg;

  // Default sizes of the value, the extra accumulator fraction and the sample count.
  localparam int unsigned VALUE_WIDTH_DEF     = 32;
  localparam int unsigned EXTRA_FRAC_BITS_DEF = 16;
  localparam int unsigned COUNT_WIDTH_DEF     = 24;

  // Command field codes.
  localparam int unsigned CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  // Ramp time and rate register formats.
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned SPM_W       = 16;
  localparam int unsigned SPM_FRAC    = 8;
  localparam int unsigned RAW_COUNT_W = TIME_W + SPM_W - SPM_FRAC;
  localparam logic [SPM_W-1:0] SPM_RESET = 16'd12288;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_set;
    logic load_stop;
    logic prep;
    logic div_start;
    logic commit;
    logic emit;
  } lrg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic retarget_pending;
    logic count_zero;
    logic div_done;
  } lrg_status_t;

endpackage

`default_nettype wire

/* rtl/lrg_div.sv */
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module lrg_div #(
  parameter int unsigned DIVIDEND_W = 49,
  parameter int unsigned DIVISOR_W  = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;
  logic                  last;

  assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign last    = cnt_q == CNT_W'(DIVIDEND_W - 1);

  assign done_o     = busy_q && last;
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

endmodule

`default_nettype wire

/* rtl/lrg_dp.sv */
`default_nettype none

// Ramp datapath: pending request registers, accumulator, step, count and divider.
module lrg_dp
  import lrg_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH     = VALUE_WIDTH_DEF,
  parameter int unsigned EXTRA_FRAC_BITS = EXTRA_FRAC_BITS_DEF,
  parameter int unsigned COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lrg_cmd_t               cmd_i,
  output lrg_status_t                 status_o,
  input  wire logic [VALUE_WIDTH-1:0] target_value_i,
  input  wire logic [TIME_W-1:0]      ramp_ms_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [SPM_W-1:0]       cfg_wdata_i,
  output logic [VALUE_WIDTH-1:0]      sample_value_o
);

  localparam int unsigned ACC_W  = VALUE_WIDTH + EXTRA_FRAC_BITS;
  localparam int unsigned DIFF_W = ACC_W + 1;
  localparam int unsigned CMP_W  = (COUNT_WIDTH > RAW_COUNT_W) ? COUNT_WIDTH : RAW_COUNT_W;

  logic [SPM_W-1:0]       spm_q, spm_d;
  logic [ACC_W-1:0]       current_acc_q, current_acc_d;
  logic [ACC_W-1:0]       step_acc_q, step_acc_d;
  logic [COUNT_WIDTH-1:0] samples_left_q, samples_left_d;
  logic [VALUE_WIDTH-1:0] final_target_q, final_target_d;
  logic [VALUE_WIDTH-1:0] pending_target_q, pending_target_d;
  logic [VALUE_WIDTH-1:0] pending_base_q, pending_base_d;
  logic [TIME_W-1:0]      pending_time_q, pending_time_d;
  logic                   stop_q, stop_d;
  logic                   rebase_q, rebase_d;
  logic                   retarget_q, retarget_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   diff_neg_q, diff_neg_d;
  logic [VALUE_WIDTH-1:0] sample_q, sample_d;

  logic [TIME_W+SPM_W-1:0] product;
  logic [CMP_W-1:0]        raw_ext;
  logic [CMP_W-1:0]        count_max;
  logic [COUNT_WIDTH-1:0]  count_sat;
  logic [ACC_W-1:0]        base_acc;
  logic [ACC_W-1:0]        cur_start;
  logic [ACC_W-1:0]        tgt_acc;
  logic [ACC_W-1:0]        final_acc;
  logic [DIFF_W-1:0]       tgt_ext;
  logic [DIFF_W-1:0]       cur_ext;
  logic                    diff_neg;
  logic [DIFF_W-1:0]       diff_mag;
  logic                    div_done;
  logic [DIFF_W-1:0]       quotient;
  logic [DIFF_W-1:0]       quotient_neg;
  logic [ACC_W-1:0]        step_sat;

  // Ramp length in samples, saturated to the count width.
  assign product   = pending_time_q * spm_q;
  assign raw_ext   = CMP_W'(product[TIME_W+SPM_W-1:SPM_FRAC]);
  assign count_max = CMP_W'({COUNT_WIDTH{1'b1}});
  assign count_sat = (raw_ext > count_max) ? {COUNT_WIDTH{1'b1}} : raw_ext[COUNT_WIDTH-1:0];

  // Q16.16 values widen into the accumulator by appending fraction bits.
  assign base_acc  = ACC_W'(pending_base_q) << EXTRA_FRAC_BITS;
  assign tgt_acc   = ACC_W'(pending_target_q) << EXTRA_FRAC_BITS;
  assign final_acc = ACC_W'(final_target_q) << EXTRA_FRAC_BITS;
  assign cur_start = rebase_q ? base_acc : current_acc_q;

  // Magnitude and sign of the distance to the target.
  assign tgt_ext  = {tgt_acc[ACC_W-1], tgt_acc};
  assign cur_ext  = {current_acc_q[ACC_W-1], current_acc_q};
  assign diff_neg = $signed(tgt_acc) < $signed(current_acc_q);
  assign diff_mag = diff_neg ? (cur_ext - tgt_ext) : (tgt_ext - cur_ext);

  lrg_div #(
    .DIVIDEND_W(DIFF_W),
    .DIVISOR_W (COUNT_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(diff_mag),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Signed step, saturated to the accumulator range.
  assign quotient_neg = -quotient;
  always_comb begin
    if (|quotient[DIFF_W-1:ACC_W-1]) begin
      step_sat = diff_neg_q ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      step_sat = diff_neg_q ? quotient_neg[ACC_W-1:0] : quotient[ACC_W-1:0];
    end
  end

  always_comb begin
    spm_d            = spm_q;
    current_acc_d    = current_acc_q;
    step_acc_d       = step_acc_q;
    samples_left_d   = samples_left_q;
    final_target_d   = final_target_q;
    pending_target_d = pending_target_q;
    pending_base_d   = pending_base_q;
    pending_time_d   = pending_time_q;
    stop_d           = stop_q;
    rebase_d         = rebase_q;
    retarget_d       = retarget_q;
    count_d          = count_q;
    diff_neg_d       = diff_neg_q;
    sample_d         = sample_q;

    if (cfg_we_i) begin
      spm_d = cfg_wdata_i;
    end
    if (cmd_i.load_set) begin
      pending_target_d = target_value_i;
      pending_time_d   = ramp_ms_i;
      stop_d           = 1'b0;
      retarget_d       = 1'b1;
      if (ramp_ms_i == '0) begin
        pending_base_d = target_value_i;
        rebase_d       = 1'b1;
      end
    end
    if (cmd_i.load_stop) begin
      stop_d     = 1'b1;
      retarget_d = 1'b1;
    end
    if (cmd_i.prep) begin
      current_acc_d = cur_start;
      if (stop_q) begin
        pending_target_d = cur_start[ACC_W-1:EXTRA_FRAC_BITS];
        count_d          = '0;
      end else begin
        count_d = count_sat;
      end
    end
    if (cmd_i.div_start) begin
      diff_neg_d = diff_neg;
    end
    if (cmd_i.commit) begin
      step_acc_d     = (count_q == '0) ? '0 : step_sat;
      samples_left_d = count_q;
      final_target_d = pending_target_q;
      stop_d         = 1'b0;
      rebase_d       = 1'b0;
      retarget_d     = 1'b0;
    end
    if (cmd_i.emit) begin
      if (samples_left_q != '0) begin
        sample_d       = current_acc_q[ACC_W-1:EXTRA_FRAC_BITS];
        current_acc_d  = current_acc_q + step_acc_q;
        samples_left_d = samples_left_q - COUNT_WIDTH'(1);
      end else begin
        sample_d      = final_target_q;
        current_acc_d = final_acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q            <= SPM_RESET;
      current_acc_q    <= '0;
      step_acc_q       <= '0;
      samples_left_q   <= '0;
      final_target_q   <= '0;
      pending_target_q <= '0;
      pending_base_q   <= '0;
      pending_time_q   <= '0;
      stop_q           <= 1'b0;
      rebase_q         <= 1'b0;
      retarget_q       <= 1'b0;
    end else begin
      spm_q            <= spm_d;
      current_acc_q    <= current_acc_d;
      step_acc_q       <= step_acc_d;
      samples_left_q   <= samples_left_d;
      final_target_q   <= final_target_d;
      pending_target_q <= pending_target_d;
      pending_base_q   <= pending_base_d;
      pending_time_q   <= pending_time_d;
      stop_q           <= stop_d;
      rebase_q         <= rebase_d;
      retarget_q       <= retarget_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    diff_neg_q <= diff_neg_d;
    sample_q   <= sample_d;
  end

  assign status_o.retarget_pending = retarget_q;
  assign status_o.count_zero       = count_q == '0;
  assign status_o.div_done         = div_done;
  assign sample_value_o            = sample_q;

endmodule

`default_nettype wire

/* rtl/lrg_ctrl.sv */
`default_nettype none

// Sequencer: takes commands, runs a retarget when a tick finds one pending,
// and owns the output valid flag.
module lrg_ctrl
  import lrg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CMD_W-1:0] command_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output lrg_cmd_t              cmd_o,
  input  wire lrg_status_t      status_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_TICK: state_d = status_i.retarget_pending ? S_PREP : S_EMIT;
            CMD_SET:  cmd_o.load_set = 1'b1;
            CMD_STOP: cmd_o.load_stop = 1'b1;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_START;
      end
      S_START: begin
        if (status_i.count_zero) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/linear_ramp_generator_top.sv */
// Linear ramp generator, one Q16.16 output sample per tick command.
// Input channel (in_valid_i / in_stall_o) carries command_i, target_value_i and
// ramp_ms_i; a transfer happens when valid is high and stall is low. A set or a
// stop command only records a pending change and produces no output. A tick
// applies any pending change and then produces exactly one sample.
// Output channel (out_valid_o / out_stall_i) carries sample_value_o from an
// output register, so a new item can be taken while a sample waits.
// Configuration: cfg_wdata_i writes the samples-per-millisecond register
// (8 fraction bits) when cfg_valid_i is high; cfg_ready_o is always high.
// Sequence: a tick with nothing pending goes through the emit step into the
// output register. A tick that applies a new ramp runs the prep, start,
// divide, commit and emit steps, the divide step waiting on the bit-serial
// step divider; a change with a zero sample count skips the divide step.
// Set and stop commands only load the pending request registers.
// Throughput: one item at a time; the input stalls while a tick is in work.
// When the receiver stalls, the sample holds and a following tick waits in the
// emit step until the output register is free.
// Reset clears the ramp state, the pending flags and the output valid flag,
// and loads 12288 (48 kHz) into the rate register.
`default_nettype none

module linear_ramp_generator_top
  import lrg_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH     = VALUE_WIDTH_DEF,
  parameter int unsigned EXTRA_FRAC_BITS = EXTRA_FRAC_BITS_DEF,
  parameter int unsigned COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [CMD_W-1:0]              command_i,
  input  wire logic signed [VALUE_WIDTH-1:0] target_value_i,
  input  wire logic [TIME_W-1:0]             ramp_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]      sample_value_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [SPM_W-1:0]              cfg_wdata_i
);

  lrg_cmd_t               cmd;
  lrg_status_t            status;
  logic [VALUE_WIDTH-1:0] sample;

  // The rate register can always take a write.
  assign cfg_ready_o    = 1'b1;
  assign sample_value_o = sample;

  lrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  lrg_dp #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .target_value_i(target_value_i),
    .ramp_ms_i     (ramp_ms_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_value_o(sample)
  );

`include "linear_ramp_generator_top_assert.svh"

  // A new sample is never written over one the receiver has not yet taken.
  `LRG_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_o || !out_stall_i)
  // The divider is only started with a nonzero sample count.
  `LRG_ASSERT_NOW(a_div_nonzero, cmd.div_start, !status.count_zero)
  // Committing a new ramp clears the pending request.
  `LRG_ASSERT_NEXT(a_commit_clears, cmd.commit, !status.retarget_pending)
  // A tick transfer always keeps the input stalled in the next cycle.
  `LRG_ASSERT_NEXT(a_tick_busy,
    in_valid_i && !in_stall_o && (command_i == CMD_TICK), in_stall_o)

endmodule

`default_nettype wire
